>>> rtl/pt_pkg.sv
// ----------------------------------------------------------------------------
// pt_pkg: shared constants for the primality tester
// Default number width and the constants of the 6k +/- 1 candidate sequence.
// ----------------------------------------------------------------------------
package pt_pkg;

    // Default width of the tested number in bits.
    localparam int unsigned NUM_WIDTH_DEFAULT = 32;

    // The lowest candidate divisor and the step between candidate pairs.
    localparam int unsigned FIRST_CAND = 5;
    localparam int unsigned CAND_STEP  = 6;

    // Offset from the lower to the upper candidate of a pair.
    localparam int unsigned PAIR_GAP = 2;

    // Small primes that are handled before the candidate loop.
    localparam int unsigned SMALL_PRIME_A = 2;
    localparam int unsigned SMALL_PRIME_B = 3;

endpackage

>>> rtl/pt_divider.sv
// ----------------------------------------------------------------------------
// pt_divider: iterative restoring divider
// Produces quotient and remainder of an unsigned division, one bit a cycle.
// ----------------------------------------------------------------------------
module pt_divider #(
    parameter int unsigned NUM_WIDTH = pt_pkg::NUM_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [NUM_WIDTH-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(NUM_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_WIDTH - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [NUM_WIDTH-1:0] dvs_reg, dvs_next;

    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;
    logic                 fits;

    // The dividend sits in the quotient register and shifts out at the top
    // while quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits the low bits.
            if (fits) begin
                rem_next = diff[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/primality_tester.sv
// ----------------------------------------------------------------------------
// primality_tester: trial-division primality test
// Reports whether an unsigned number is prime, trying the divisor pairs
// 6k - 1 and 6k + 1 on one shared iterative divider.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Ports                          Contents
// s_        in         s_valid, s_ready, s_number     number to test
// m_        out        m_valid, m_ready, m_is_prime   1 if the number is prime
//
// One request at a time; s_ready is high only while the sequencer is idle.
// A prime costs one division by 3, two per candidate pair tried and one that ends the loop
// (10922 pairs for the largest 32-bit prime). Numbers settled without the divider skip the
// divisions; a low m_ready holds the result until it is taken.
// Reset is synchronous and active low; it idles the sequencer and drops m_valid.
//
module primality_tester #(
    parameter int unsigned NUM_WIDTH = pt_pkg::NUM_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [NUM_WIDTH-1:0] s_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_prime
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_WAIT_THREE,
        ST_WAIT_LOW,
        ST_WAIT_HIGH,
        ST_RESULT
    } state_t;

    localparam logic [NUM_WIDTH-1:0] PRIME_A    = NUM_WIDTH'(pt_pkg::SMALL_PRIME_A);
    localparam logic [NUM_WIDTH-1:0] PRIME_B    = NUM_WIDTH'(pt_pkg::SMALL_PRIME_B);
    localparam logic [NUM_WIDTH-1:0] FIRST_CAND = NUM_WIDTH'(pt_pkg::FIRST_CAND);
    localparam logic [NUM_WIDTH-1:0] CAND_STEP  = NUM_WIDTH'(pt_pkg::CAND_STEP);
    localparam logic [NUM_WIDTH-1:0] PAIR_GAP   = NUM_WIDTH'(pt_pkg::PAIR_GAP);
    localparam logic [NUM_WIDTH-1:0] ONE        = NUM_WIDTH'(1);

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] number_reg, number_next;
    logic [NUM_WIDTH-1:0] cand_reg, cand_next;
    logic [NUM_WIDTH-1:0] divisor_reg, divisor_next;
    logic                 start_reg, start_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 is_prime_reg, is_prime_next;

    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_quotient;
    logic [NUM_WIDTH-1:0] div_remainder;
    logic                 rem_zero;

    pt_divider #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (number_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign rem_zero = (div_remainder == '0);

    // The sequencer. Every division is started with a one-cycle pulse and the
    // state waits for the divider's done pulse before deciding the next step.
    always_comb begin
        state_next    = state_reg;
        number_next   = number_reg;
        cand_next     = cand_reg;
        divisor_next  = divisor_reg;
        start_next    = 1'b0;
        m_valid_next  = m_valid_reg;
        is_prime_next = is_prime_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    number_next = s_number;
                    state_next  = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (number_reg == PRIME_A || number_reg == PRIME_B) begin
                    is_prime_next = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_RESULT;
                end else if (number_reg <= ONE || !number_reg[0]) begin
                    // Zero, one and even numbers are not prime.
                    is_prime_next = 1'b0;
                    m_valid_next  = 1'b1;
                    state_next    = ST_RESULT;
                end else begin
                    divisor_next = PRIME_B;
                    start_next   = 1'b1;
                    state_next   = ST_WAIT_THREE;
                end
            end
            ST_WAIT_THREE: begin
                if (div_done) begin
                    if (rem_zero) begin
                        is_prime_next = 1'b0;
                        m_valid_next  = 1'b1;
                        state_next    = ST_RESULT;
                    end else begin
                        cand_next    = FIRST_CAND;
                        divisor_next = FIRST_CAND;
                        start_next   = 1'b1;
                        state_next   = ST_WAIT_LOW;
                    end
                end
            end
            ST_WAIT_LOW: begin
                // The quotient by the lower candidate also gives the loop
                // bound: once the candidate exceeds it, no factor remains.
                if (div_done) begin
                    if (cand_reg > div_quotient) begin
                        is_prime_next = 1'b1;
                        m_valid_next  = 1'b1;
                        state_next    = ST_RESULT;
                    end else if (rem_zero) begin
                        is_prime_next = 1'b0;
                        m_valid_next  = 1'b1;
                        state_next    = ST_RESULT;
                    end else begin
                        divisor_next = cand_reg + PAIR_GAP;
                        start_next   = 1'b1;
                        state_next   = ST_WAIT_HIGH;
                    end
                end
            end
            ST_WAIT_HIGH: begin
                if (div_done) begin
                    if (rem_zero) begin
                        is_prime_next = 1'b0;
                        m_valid_next  = 1'b1;
                        state_next    = ST_RESULT;
                    end else begin
                        cand_next    = cand_reg + CAND_STEP;
                        divisor_next = cand_reg + CAND_STEP;
                        start_next   = 1'b1;
                        state_next   = ST_WAIT_LOW;
                    end
                end
            end
            ST_RESULT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                m_valid_next = 1'b0;
                state_next   = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        number_reg   <= number_next;
        cand_reg     <= cand_next;
        divisor_reg  <= divisor_next;
        is_prime_reg <= is_prime_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_is_prime = is_prime_reg;

endmodule
